// ===== hdl/i2css_pkg.sv =====
// Shared types, codes and a helper function of the I2C shadow register sync block.
package i2css_pkg;

    localparam int IDX_W  = 5;
    localparam int MAX_WR = 16;
    localparam int MAX_WR_IW = 4;

    typedef enum logic [2:0] {
        FN_POLL       = 3'd0,
        FN_REFRESH    = 3'd1,
        FN_BUS_EVENT  = 3'd2,
        FN_HOST_WRITE = 3'd3,
        FN_HOST_READ  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_TX_READY  = 3'd0,
        ST_BYTE_SENT = 3'd1,
        ST_RX_READY  = 3'd2,
        ST_BYTE_RECV = 3'd3,
        ST_LAST_RECV = 3'd4,
        ST_ERROR     = 3'd5
    } t_bus_status;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_REQUEST  = 3'd1,
        CMD_RESTART  = 3'd2,
        CMD_TRANSMIT = 3'd3,
        CMD_NACK     = 3'd4
    } t_bus_cmd;

    typedef struct packed {
        logic [2:0]       func;
        logic [2:0]       bus_status;
        logic [7:0]       bus_data;
        logic [IDX_W-1:0] host_addr;
        logic [7:0]       host_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0] bus_cmd;
        logic       bus_write_dir;
        logic [7:0] bus_byte;
        logic       keep_transfer;
        logic [7:0] host_rdata;
        logic       busy_res;
        logic       failure;
    } t_out_item;

    typedef struct packed {
        logic [IDX_W-1:0] found;
        logic             jump;
    } t_seek;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [MAX_WR_IW-1:0] f_lowest(input logic [MAX_WR-1:0] vec);
        logic [MAX_WR_IW-1:0] idx;
        idx = '0;
        for (int i = MAX_WR - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = MAX_WR_IW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hdl/i2css_seek.sv =====
// Next-dirty search: finds the next dirty register from the current index, wrapping to zero.
module i2css_seek #(
    parameter int NUM_WRITABLE = 16
) (
    input  logic [i2css_pkg::MAX_WR-1:0] i_dirty,
    input  logic [i2css_pkg::IDX_W-1:0]  i_cur,
    output i2css_pkg::t_seek             o_seek
);
    import i2css_pkg::*;

    logic [IDX_W-1:0]  start_idx;
    logic [MAX_WR-1:0] upper;
    logic [IDX_W-1:0]  found;

    always_comb begin
        start_idx = (i_cur < IDX_W'(NUM_WRITABLE)) ? i_cur : '0;
        for (int i = 0; i < MAX_WR; i++) begin
            upper[i] = i_dirty[i] && (IDX_W'(i) >= start_idx);
        end
        if (upper != '0) begin
            found = IDX_W'(f_lowest(upper));
        end else begin
            found = IDX_W'(f_lowest(i_dirty));
        end
        o_seek.found = found;
        o_seek.jump  = (found != i_cur);
    end

endmodule

// ===== hdl/i2css_engine.sv =====
// Shadow register file, dirty mask and transfer sequencing for one registered transaction.
module i2css_engine #(
    parameter int NUM_SHADOW   = 19,
    parameter int NUM_WRITABLE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  i2css_pkg::t_in_item  i_item,
    output i2css_pkg::t_out_item o_result
);
    import i2css_pkg::*;

    localparam int SH_IW = (NUM_SHADOW > 1) ? $clog2(NUM_SHADOW) : 1;
    localparam int DW_IW = (NUM_WRITABLE > 1) ? $clog2(NUM_WRITABLE) : 1;
    localparam logic [IDX_W-1:0] NS_L   = IDX_W'(NUM_SHADOW);
    localparam logic [IDX_W-1:0] NS_M1  = IDX_W'(NUM_SHADOW - 1);
    localparam logic [IDX_W-1:0] NW_L   = IDX_W'(NUM_WRITABLE);

    logic [7:0]              r_shadow [NUM_SHADOW];
    logic [NUM_WRITABLE-1:0] r_dirty, n_dirty;
    logic [IDX_W-1:0]        r_cur, n_cur;
    logic                    r_rd_act, n_rd_act;
    logic                    r_wr_act, n_wr_act;
    logic                    r_refresh, n_refresh;
    logic                    r_addr_ph, n_addr_ph;
    logic                    r_fail, n_fail;

    logic              sh_we;
    logic [SH_IW-1:0]  sh_waddr;
    logic [7:0]        sh_wdata;
    logic [IDX_W-1:0]  rd_idx;
    logic [7:0]        rd_byte;
    logic [MAX_WR-1:0] dirty_pad;
    logic [IDX_W-1:0]  seek_cur;
    t_seek             seek;
    logic              cur_dirty;

    always_comb begin
        dirty_pad = '0;
        dirty_pad[NUM_WRITABLE-1:0] = r_dirty;
    end

    // A poll restarts the search from index zero.
    assign seek_cur = (i_item.func == FN_POLL) ? '0 : r_cur;

    i2css_seek #(
        .NUM_WRITABLE(NUM_WRITABLE)
    ) u_seek (
        .i_dirty(dirty_pad),
        .i_cur  (seek_cur),
        .o_seek (seek)
    );

    // One read port serves both the host read and the byte sent during a write run.
    always_comb begin
        rd_idx  = (i_item.func == FN_HOST_READ) ? i_item.host_addr : seek.found;
        rd_byte = (rd_idx < NS_L) ? r_shadow[rd_idx[SH_IW-1:0]] : 8'h00;
    end

    assign cur_dirty = (r_cur < NW_L) && dirty_pad[r_cur[MAX_WR_IW-1:0]];

    always_comb begin
        n_dirty   = r_dirty;
        n_cur     = r_cur;
        n_rd_act  = r_rd_act;
        n_wr_act  = r_wr_act;
        n_refresh = r_refresh;
        n_addr_ph = r_addr_ph;
        n_fail    = r_fail;
        sh_we     = 1'b0;
        sh_waddr  = r_cur[SH_IW-1:0];
        sh_wdata  = i_item.bus_data;
        o_result  = '0;

        case (i_item.func)
            FN_POLL: begin
                if (!r_rd_act && !r_wr_act) begin
                    if (r_dirty != '0) begin
                        n_wr_act = 1'b1;
                        n_cur    = seek.found;
                        o_result.bus_cmd       = CMD_REQUEST;
                        o_result.bus_write_dir = 1'b1;
                    end else if (r_refresh) begin
                        n_refresh = 1'b0;
                        n_rd_act  = 1'b1;
                        if (r_cur != '0) begin
                            n_addr_ph = 1'b1;
                            n_cur     = '0;
                        end
                        o_result.bus_cmd       = CMD_REQUEST;
                        o_result.bus_write_dir = n_addr_ph;
                    end
                end
            end
            FN_REFRESH: begin
                n_refresh = 1'b1;
            end
            FN_BUS_EVENT: begin
                if (r_rd_act) begin
                    o_result.keep_transfer = 1'b1;
                    if (r_addr_ph) begin
                        if (i_item.bus_status == ST_TX_READY) begin
                            o_result.bus_cmd  = CMD_TRANSMIT;
                            o_result.bus_byte = 8'(r_cur);
                        end else if (i_item.bus_status == ST_BYTE_SENT) begin
                            o_result.bus_cmd = CMD_RESTART;
                            n_addr_ph = 1'b0;
                        end else begin
                            n_rd_act = 1'b0;
                            n_fail   = 1'b1;
                            o_result.keep_transfer = 1'b0;
                        end
                    end else if (i_item.bus_status == ST_RX_READY) begin
                        n_rd_act = r_rd_act;
                    end else if (i_item.bus_status == ST_BYTE_RECV) begin
                        // Bytes the host has changed since are kept.
                        sh_we = (r_cur < NS_L) && !cur_dirty;
                        n_cur = r_cur + 1'b1;
                        if (n_cur == NS_M1) begin
                            o_result.bus_cmd = CMD_NACK;
                        end
                    end else if (i_item.bus_status == ST_LAST_RECV) begin
                        sh_we = (r_cur < NS_L);
                        n_cur = r_cur + 1'b1;
                        if (n_cur > NS_M1) begin
                            n_cur = '0;
                        end
                        n_rd_act = 1'b0;
                        o_result.keep_transfer = 1'b0;
                    end else begin
                        n_rd_act = 1'b0;
                        n_fail   = 1'b1;
                        o_result.keep_transfer = 1'b0;
                    end
                end else if (r_wr_act) begin
                    o_result.keep_transfer = 1'b1;
                    if (i_item.bus_status == ST_TX_READY) begin
                        o_result.bus_cmd  = CMD_TRANSMIT;
                        o_result.bus_byte = 8'(r_cur);
                    end else if (i_item.bus_status == ST_BYTE_SENT) begin
                        if (r_dirty != '0) begin
                            if (seek.jump) begin
                                n_cur = seek.found;
                                o_result.bus_cmd       = CMD_RESTART;
                                o_result.bus_write_dir = 1'b1;
                            end else begin
                                o_result.bus_cmd  = CMD_TRANSMIT;
                                o_result.bus_byte = rd_byte;
                                n_dirty[seek.found[DW_IW-1:0]] = 1'b0;
                                n_cur = seek.found + 1'b1;
                            end
                        end else begin
                            n_wr_act = 1'b0;
                            o_result.keep_transfer = 1'b0;
                        end
                    end else begin
                        n_wr_act = 1'b0;
                        n_fail   = 1'b1;
                        o_result.keep_transfer = 1'b0;
                    end
                end
            end
            FN_HOST_WRITE: begin
                sh_waddr = i_item.host_addr[SH_IW-1:0];
                sh_wdata = i_item.host_data;
                if (i_item.host_addr < NS_L) begin
                    sh_we = 1'b1;
                    if (i_item.host_addr < NW_L) begin
                        n_dirty[i_item.host_addr[DW_IW-1:0]] = 1'b1;
                    end
                end
            end
            FN_HOST_READ: begin
                o_result.host_rdata = rd_byte;
            end
            default: begin
                n_fail = r_fail;
            end
        endcase

        o_result.busy_res = n_rd_act || n_wr_act;
        o_result.failure  = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SHADOW; i++) begin
                r_shadow[i] <= 8'h00;
            end
            r_dirty   <= '0;
            r_cur     <= '1;
            r_rd_act  <= 1'b0;
            r_wr_act  <= 1'b0;
            r_refresh <= 1'b0;
            r_addr_ph <= 1'b0;
            r_fail    <= 1'b0;
        end else if (i_valid) begin
            if (sh_we) begin
                r_shadow[sh_waddr] <= sh_wdata;
            end
            r_dirty   <= n_dirty;
            r_cur     <= n_cur;
            r_rd_act  <= n_rd_act;
            r_wr_act  <= n_wr_act;
            r_refresh <= n_refresh;
            r_addr_ph <= n_addr_ph;
            r_fail    <= n_fail;
        end
    end

endmodule

// ===== hdl/i2c_shadow_register_sync_core.sv =====
// Top level of the I2C shadow register sync block: input and result registers around the engine.
// A transaction taken into the input register gives its result in the result register,
// marked by o_done; one transaction is accepted in every cycle while busy is low, set by
// the single pass through the next-dirty search and the shadow register read between the
// two registers. Reset clears the shadow registers, dirty mask and flags, sets the current
// index to 31, and keeps busy high until the clock edge after reset is released.
module i2c_shadow_register_sync_core #(
    parameter int NUM_SHADOW   = 19,
    parameter int NUM_WRITABLE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  i2css_pkg::t_in_item  i_item,
    output logic                 o_done,
    output i2css_pkg::t_out_item o_result
);
    import i2css_pkg::*;

    logic      r_ready;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_done;
    t_out_item r_out;
    t_out_item n_out;

    assign busy = !r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_ready    <= 1'b1;
            r_in_valid <= start && r_ready;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && r_ready) begin
            r_in <= i_item;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    i2css_engine #(
        .NUM_SHADOW  (NUM_SHADOW),
        .NUM_WRITABLE(NUM_WRITABLE)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_in),
        .o_result(n_out)
    );

    assign o_done   = r_done;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_done)
        else $error("accepted transaction produced no result");

    a_keep_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.keep_transfer |-> o_result.busy_res)
        else $error("transfer kept open with no sequence active");

    a_rdata_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.host_rdata != 8'h00) |-> $past(r_in.func) == FN_HOST_READ)
        else $error("host read data on a transaction that is not a host read");
`endif

endmodule

// ===== tb/sv/i2c_shadow_register_sync_core_tb.sv =====
// Self-checking testbench for the I2C shadow register sync core, with a cycle-free mirror of its behaviour.
module i2c_shadow_register_sync_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import i2css_pkg::*;

    localparam int N_SHADOW    = 19;
    localparam int N_WRITABLE  = 16;
    localparam int ITEM_TARGET = 1170;
    localparam int STEADY_LO   = 500;
    localparam int STEADY_HI   = 800;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  item_d  = '0;
    logic      o_done;
    t_out_item o_result;

    // Mirror of the shadow copy, the dirty mask and the sequencer flags.
    logic [7:0]            mir_regs [N_SHADOW];
    logic [N_WRITABLE-1:0] mir_dirty;
    logic [IDX_W-1:0]      mir_idx;
    logic                  mir_rd;
    logic                  mir_wr;
    logic                  mir_refresh;
    logic                  mir_addr_phase;
    logic                  mir_fail;

    t_out_item  pending_results [$];
    logic [2:0] link_cmd   = CMD_NONE;
    int         n_items    = 0;
    int         n_mismatch = 0;

    i2c_shadow_register_sync_core #(
        .NUM_SHADOW  (N_SHADOW),
        .NUM_WRITABLE(N_WRITABLE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (item_d),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [7:0] shadow_byte(input logic [IDX_W-1:0] idx);
        return (idx < N_SHADOW) ? mir_regs[idx] : 8'h00;
    endfunction

    // Moves the current index to the next dirty entry, wrapping to zero; true on a jump.
    function automatic logic seek_next_dirty();
        logic [IDX_W-1:0] from;
        logic [IDX_W-1:0] hit_idx;
        logic             hit;
        logic             jump;
        from    = (mir_idx < N_WRITABLE) ? mir_idx : '0;
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < N_WRITABLE; i++) begin
            if (!hit && i >= from && mir_dirty[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < N_WRITABLE; i++) begin
            if (!hit && i < from && mir_dirty[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
        jump    = (hit_idx != mir_idx);
        mir_idx = hit_idx;
        return jump;
    endfunction

    task automatic predict_transaction(input t_in_item it, output t_out_item res);
        res = '0;
        case (it.func)
            FN_POLL: begin
                if (!mir_rd && !mir_wr) begin
                    if (mir_dirty != '0) begin
                        mir_wr  = 1'b1;
                        mir_idx = '0;
                        void'(seek_next_dirty());
                        res.bus_cmd       = CMD_REQUEST;
                        res.bus_write_dir = 1'b1;
                    end else if (mir_refresh) begin
                        mir_refresh = 1'b0;
                        mir_rd      = 1'b1;
                        if (mir_idx != '0) begin
                            mir_addr_phase = 1'b1;
                            mir_idx        = '0;
                        end
                        res.bus_cmd       = CMD_REQUEST;
                        res.bus_write_dir = mir_addr_phase;
                    end
                end
            end
            FN_REFRESH: begin
                mir_refresh = 1'b1;
            end
            FN_BUS_EVENT: begin
                if (mir_rd) begin
                    res.keep_transfer = 1'b1;
                    if (mir_addr_phase) begin
                        if (it.bus_status == ST_TX_READY) begin
                            res.bus_cmd  = CMD_TRANSMIT;
                            res.bus_byte = 8'(mir_idx);
                        end else if (it.bus_status == ST_BYTE_SENT) begin
                            res.bus_cmd    = CMD_RESTART;
                            mir_addr_phase = 1'b0;
                        end else begin
                            mir_rd            = 1'b0;
                            mir_fail          = 1'b1;
                            res.keep_transfer = 1'b0;
                        end
                    end else if (it.bus_status == ST_RX_READY) begin
                        // The receiver is simply waiting for the next byte.
                    end else if (it.bus_status == ST_BYTE_RECV) begin
                        // Bytes the host has changed since the last write must survive the read.
                        if (mir_idx < N_SHADOW &&
                            (mir_idx >= N_WRITABLE || !mir_dirty[mir_idx])) begin
                            mir_regs[mir_idx] = it.bus_data;
                        end
                        mir_idx = mir_idx + 1'b1;
                        if (mir_idx == N_SHADOW - 1) begin
                            res.bus_cmd = CMD_NACK;
                        end
                    end else if (it.bus_status == ST_LAST_RECV) begin
                        if (mir_idx < N_SHADOW) begin
                            mir_regs[mir_idx] = it.bus_data;
                        end
                        mir_idx = mir_idx + 1'b1;
                        if (mir_idx > N_SHADOW - 1) begin
                            mir_idx = '0;
                        end
                        mir_rd            = 1'b0;
                        res.keep_transfer = 1'b0;
                    end else begin
                        mir_rd            = 1'b0;
                        mir_fail          = 1'b1;
                        res.keep_transfer = 1'b0;
                    end
                end else if (mir_wr) begin
                    res.keep_transfer = 1'b1;
                    if (it.bus_status == ST_TX_READY) begin
                        res.bus_cmd  = CMD_TRANSMIT;
                        res.bus_byte = 8'(mir_idx);
                    end else if (it.bus_status == ST_BYTE_SENT) begin
                        if (mir_dirty != '0) begin
                            if (seek_next_dirty()) begin
                                res.bus_cmd       = CMD_RESTART;
                                res.bus_write_dir = 1'b1;
                            end else begin
                                res.bus_cmd        = CMD_TRANSMIT;
                                res.bus_byte       = shadow_byte(mir_idx);
                                mir_dirty[mir_idx] = 1'b0;
                                mir_idx            = mir_idx + 1'b1;
                            end
                        end else begin
                            mir_wr            = 1'b0;
                            res.keep_transfer = 1'b0;
                        end
                    end else begin
                        mir_wr            = 1'b0;
                        mir_fail          = 1'b1;
                        res.keep_transfer = 1'b0;
                    end
                end
            end
            FN_HOST_WRITE: begin
                if (it.host_addr < N_SHADOW) begin
                    mir_regs[it.host_addr] = it.host_data;
                    if (it.host_addr < N_WRITABLE) begin
                        mir_dirty[it.host_addr] = 1'b1;
                    end
                end
            end
            FN_HOST_READ: begin
                res.host_rdata = shadow_byte(it.host_addr);
            end
            default: begin
            end
        endcase
        res.busy_res = mir_rd | mir_wr;
        res.failure  = mir_fail;
    endtask

    function automatic t_in_item make_item(input logic [2:0] fn, input logic [2:0] st,
                                           input logic [7:0] bd, input logic [IDX_W-1:0] ha,
                                           input logic [7:0] hd);
        t_in_item it;
        it.func       = fn;
        it.bus_status = st;
        it.bus_data   = bd;
        it.host_addr  = ha;
        it.host_data  = hd;
        return it;
    endfunction

    function automatic t_in_item random_item();
        return make_item(3'($urandom_range(7)), 3'($urandom_range(7)), 8'($urandom),
                         IDX_W'($urandom), 8'($urandom));
    endfunction

    // What a well-behaved bus controller reports next, given the last command it was given.
    function automatic logic [2:0] next_bus_status();
        if (mir_wr || mir_addr_phase) begin
            return (link_cmd == CMD_TRANSMIT) ? ST_BYTE_SENT : ST_TX_READY;
        end
        if (link_cmd == CMD_NACK) begin
            return ST_LAST_RECV;
        end
        return ($urandom_range(5) == 0) ? ST_RX_READY : ST_BYTE_RECV;
    endfunction

    task automatic send_item(input t_in_item it);
        t_out_item res;
        logic      ignored;
        start  <= 1'b1;
        item_d <= it;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        ignored = (it.func > FN_HOST_READ) || (it.func == FN_BUS_EVENT && !mir_rd && !mir_wr);
        predict_transaction(it, res);
        pending_results.push_back(res);
        if (res.bus_cmd != CMD_NONE) begin
            link_cmd = res.bus_cmd;
        end
        if (!ignored) begin
            n_items++;
        end
        // Random idle gaps between items, but none while the item count is in the steady window.
        if (!(n_items >= STEADY_LO && n_items < STEADY_HI) && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Plays the bus side until the running sequence ends, with some noise and broken events.
    task automatic drive_sequence(input int noise_pct);
        t_in_item it;
        while (mir_rd || mir_wr) begin
            if ($urandom_range(99) < noise_pct) begin
                if ($urandom_range(1) == 1) begin
                    it = random_item();
                end else begin
                    it = make_item(FN_BUS_EVENT, 3'($urandom_range(7)), 8'($urandom),
                                   IDX_W'($urandom), 8'($urandom));
                end
            end else begin
                it = make_item(FN_BUS_EVENT, next_bus_status(), 8'($urandom),
                               IDX_W'($urandom), 8'($urandom));
            end
            send_item(it);
        end
    endtask

    task automatic test_host_access();
        send_item(make_item(FN_HOST_WRITE, ST_TX_READY, 8'h00, 5'd0, 8'hFF));
        send_item(make_item(FN_HOST_WRITE, ST_TX_READY, 8'h00, 5'd15, 8'h00));
        send_item(make_item(FN_HOST_WRITE, ST_TX_READY, 8'h00, 5'd16, 8'hA5));
        send_item(make_item(FN_HOST_WRITE, ST_TX_READY, 8'h00, 5'd18, 8'h3C));
        send_item(make_item(FN_HOST_WRITE, ST_TX_READY, 8'h00, 5'd19, 8'h77));
        send_item(make_item(FN_HOST_WRITE, ST_TX_READY, 8'h00, 5'd31, 8'hFF));
        send_item(make_item(FN_HOST_READ, ST_TX_READY, 8'h00, 5'd0, 8'h00));
        send_item(make_item(FN_HOST_READ, ST_TX_READY, 8'h00, 5'd16, 8'h00));
        send_item(make_item(FN_HOST_READ, ST_TX_READY, 8'h00, 5'd18, 8'h00));
        send_item(make_item(FN_HOST_READ, ST_TX_READY, 8'h00, 5'd19, 8'h00));
        send_item(make_item(FN_HOST_READ, ST_TX_READY, 8'h00, 5'd31, 8'h00));
        send_item(make_item(3'd5, ST_ERROR, 8'hFF, 5'd31, 8'hFF));
        send_item(make_item(3'd7, 3'd7, 8'h00, 5'd0, 8'h00));
        // A bus event with nothing running must be ignored.
        send_item(make_item(FN_BUS_EVENT, ST_BYTE_RECV, 8'hFF, 5'd0, 8'h00));
    endtask

    task automatic test_dirty_write();
        // Entries 0 and 15 are dirty, so the second run needs a repeated start.
        send_item(make_item(FN_POLL, ST_TX_READY, 8'h00, 5'd0, 8'h00));
        send_item(make_item(FN_POLL, ST_TX_READY, 8'h00, 5'd0, 8'h00));
        drive_sequence(0);
    endtask

    task automatic test_bus_error();
        send_item(make_item(FN_REFRESH, ST_TX_READY, 8'h00, 5'd0, 8'h00));
        send_item(make_item(FN_POLL, ST_TX_READY, 8'h00, 5'd0, 8'h00));
        send_item(make_item(FN_BUS_EVENT, ST_TX_READY, 8'h00, 5'd0, 8'h00));
        send_item(make_item(FN_BUS_EVENT, 3'd7, 8'h00, 5'd0, 8'h00));
    endtask

    task automatic test_random_traffic();
        int               n_wr;
        int               base;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
        while (n_items < ITEM_TARGET) begin
            n_wr = ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 4);
            base = $urandom_range(0, N_WRITABLE - 1);
            for (int k = 0; k < n_wr; k++) begin
                addr = ($urandom_range(7) == 0) ? IDX_W'($urandom) : IDX_W'(base + k);
                data = ($urandom_range(7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
                send_item(make_item(FN_HOST_WRITE, 3'($urandom_range(7)), 8'($urandom),
                                    addr, data));
            end
            if ($urandom_range(99) < 60) begin
                send_item(make_item(FN_REFRESH, 3'($urandom_range(7)), 8'($urandom),
                                    IDX_W'($urandom), 8'($urandom)));
            end
            if ($urandom_range(99) < 30) begin
                send_item(make_item(FN_HOST_READ, 3'($urandom_range(7)), 8'($urandom),
                                    IDX_W'($urandom), 8'($urandom)));
            end
            if ($urandom_range(99) < 10) begin
                send_item(random_item());
            end
            send_item(make_item(FN_POLL, 3'($urandom_range(7)), 8'($urandom),
                                IDX_W'($urandom), 8'($urandom)));
            drive_sequence(7);
        end
    endtask

    task automatic report_mismatch(input string why, input t_out_item want,
                                   input t_out_item got);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("%0t ns: %s: expected cmd=%0d dir=%0d byte=%02h keep=%0d rdata=%02h",
                     $realtime, why, want.bus_cmd, want.bus_write_dir, want.bus_byte,
                     want.keep_transfer, want.host_rdata);
            $display("    busy=%0d fail=%0d, got cmd=%0d dir=%0d byte=%02h keep=%0d",
                     want.busy_res, want.failure, got.bus_cmd, got.bus_write_dir,
                     got.bus_byte, got.keep_transfer);
            $display("    rdata=%02h busy=%0d fail=%0d",
                     got.host_rdata, got.busy_res, got.failure);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", '0, o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.bus_cmd !== want.bus_cmd ||
                    o_result.bus_write_dir !== want.bus_write_dir ||
                    o_result.bus_byte !== want.bus_byte ||
                    o_result.keep_transfer !== want.keep_transfer ||
                    o_result.host_rdata !== want.host_rdata ||
                    o_result.busy_res !== want.busy_res ||
                    o_result.failure !== want.failure) begin
                    report_mismatch("result mismatch", want, o_result);
                end
            end
        end
    end

    initial begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        for (int i = 0; i < N_SHADOW; i++) begin
            mir_regs[i] = 8'h00;
        end
        mir_dirty      = '0;
        mir_idx        = 5'h1f;
        mir_rd         = 1'b0;
        mir_wr         = 1'b0;
        mir_refresh    = 1'b0;
        mir_addr_phase = 1'b0;
        mir_fail       = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_host_access();
        test_dirty_write();
        test_bus_error();
        test_random_traffic();

        start <= 1'b0;
        for (int w = 0; w < 200 && pending_results.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/i2css_pkg.sv
hdl/i2css_seek.sv
hdl/i2css_engine.sv
hdl/i2c_shadow_register_sync_core.sv
tb/sv/i2c_shadow_register_sync_core_tb.sv
